// File: hdl/u16t_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16t_pkg
// Shared sizes, code points and record types of the UTF-16 title converter.
// ----------------------------------------------------------------------------
package u16t_pkg;

  localparam int NameBuffer = 128;
  localparam int TitleUnits = 64;

  localparam int UnitW = 16;
  localparam int ByteW = 8;
  localparam int CharW = 7;
  localparam int EmitW = $clog2(NameBuffer - 3);
  localparam int IdxW  = $clog2(TitleUnits + 1);
  localparam int WideW = 2;

  localparam logic [EmitW-1:0] OutLimit  = EmitW'(NameBuffer - 4);
  localparam logic [IdxW-1:0]  UnitLimit = IdxW'(TitleUnits);
  localparam logic [EmitW-1:0] MinChars  = EmitW'(3);
  localparam logic [WideW-1:0] WideSat   = '1;

  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [UnitW-1:0] LineFeed  = 16'h000A;
  localparam logic [UnitW-1:0] CarRet    = 16'h000D;
  localparam logic [UnitW-1:0] Latin1Top = 16'h00FF;
  localparam logic [ByteW-1:0] SpaceChar = 8'h20;

  typedef struct packed {
    logic [EmitW-1:0] emitted_count;
    logic [IdxW-1:0]  unit_index;
    logic [WideW-1:0] wide_count;
    logic             last_was_space;
    logic             high_pending;
    logic             stopped;
  } title_state_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             title_done;
    logic             discard_title;
    logic [CharW-1:0] char_count;
  } title_result_t;

endpackage

// File: hdl/u16t_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16t_step
// Per-word conversion: surrogate joining, newline folding, Latin-1 folding,
// limits and counters. Pure combinational next state and result.
// ----------------------------------------------------------------------------
module u16t_step import u16t_pkg::*; (
  input  logic [UnitW-1:0] code_unit,
  input  logic             final_unit,
  input  title_state_t     cur,
  output title_state_t     nxt,
  output title_result_t    res
);

  function automatic logic [ByteW-1:0] fold_latin1(input logic [ByteW-1:0] cp);
    logic [ByteW-1:0] r;
    case (cp)
      8'hE4:   r = "a";
      8'hF6:   r = "o";
      8'hFC:   r = "u";
      8'hC4:   r = "A";
      8'hD6:   r = "O";
      8'hDC:   r = "U";
      8'hDF:   r = "s";
      8'hE9:   r = "e";
      default: r = cp;
    endcase
    return r;
  endfunction

  logic             is_low;
  logic             is_high;
  logic             is_nl;
  logic             proc;
  logic [1:0]       wide_add;
  logic [WideW:0]   wide_sum;
  logic             valid;
  logic [ByteW-1:0] byte_out;

  assign is_low  = (code_unit >= LowFirst) && (code_unit <= LowLast);
  assign is_high = (code_unit >= HighFirst) && (code_unit <= HighLast);
  assign is_nl   = (code_unit == LineFeed) || (code_unit == CarRet);

  always_comb begin
    nxt      = cur;
    proc     = !cur.stopped;
    wide_add = 2'd0;
    valid    = 1'b0;
    byte_out = '0;

    // pending high surrogate resolves on this word
    if (proc && cur.high_pending) begin
      nxt.high_pending = 1'b0;
      wide_add         = 2'd1;
      if (is_low) begin
        proc = 1'b0;
        if (cur.unit_index != UnitLimit) begin
          nxt.unit_index = cur.unit_index + 1'b1;
        end
      end
    end

    if (proc) begin
      if (cur.unit_index >= UnitLimit || cur.emitted_count >= OutLimit) begin
        nxt.stopped = 1'b1;
      end else begin
        nxt.unit_index = cur.unit_index + 1'b1;
        if (code_unit == '0) begin
          nxt.stopped = 1'b1;
        end else if (is_nl) begin
          if (cur.emitted_count != '0 && !cur.last_was_space) begin
            valid    = 1'b1;
            byte_out = SpaceChar;
          end
        end else if (is_high) begin
          nxt.high_pending = 1'b1;
        end else if (code_unit <= Latin1Top) begin
          valid    = 1'b1;
          byte_out = fold_latin1(code_unit[ByteW-1:0]);
        end else begin
          wide_add = wide_add + 2'd1;
        end
      end
    end

    if (valid) begin
      nxt.emitted_count  = cur.emitted_count + 1'b1;
      nxt.last_was_space = (byte_out == SpaceChar);
    end

    // high surrogate left dangling at the end of the slot
    if (final_unit && nxt.high_pending && !nxt.stopped) begin
      wide_add = wide_add + 2'd1;
    end

    wide_sum = {1'b0, cur.wide_count} + (WideW+1)'(wide_add);
    if (wide_sum > (WideW+1)'(WideSat)) begin
      nxt.wide_count = WideSat;
    end else begin
      nxt.wide_count = wide_sum[WideW-1:0];
    end

    res.out_byte      = byte_out;
    res.byte_valid    = valid;
    res.title_done    = final_unit;
    res.discard_title = final_unit && (nxt.emitted_count < MinChars)
                        && (nxt.wide_count == WideSat);
    res.char_count    = CharW'(nxt.emitted_count);

    if (final_unit) begin
      nxt = '0;
    end
  end

endmodule

// File: hdl/utf16_title_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_title_to_ascii
// Converts a stream of UTF-16 title words into Latin-1 bytes with title
// bookkeeping (char count, discard flag on the last word).
//
// Pipeline: accepted words enter the input register, which feeds the
//   conversion logic; the result register loads when the output can take it.
// Throughput: one word per cycle while results are taken; the title state updates with each word.
// Reset: synchronous rst clears both stage valids and the title state.
// ----------------------------------------------------------------------------
module utf16_title_to_ascii import u16t_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             unit_valid,
  output logic             unit_ready,
  input  logic [UnitW-1:0] code_unit,
  input  logic             final_unit,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             byte_valid,
  output logic             title_done,
  output logic             discard_title,
  output logic [CharW-1:0] char_count
);

  logic             s1_valid;
  logic [UnitW-1:0] s1_code;
  logic             s1_final;
  logic             s2_take;
  logic             s1_ready;
  title_state_t     state;
  title_state_t     state_next;
  title_result_t    res_next;
  title_result_t    res;

  assign s2_take    = s1_valid && (!result_valid || result_ready);
  assign s1_ready   = !s1_valid || s2_take;
  assign unit_ready = s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= unit_valid;
    end
    if (s1_ready && unit_valid) begin
      s1_code  <= code_unit;
      s1_final <= final_unit;
    end
  end

  u16t_step u_step (
    .code_unit  (s1_code),
    .final_unit (s1_final),
    .cur        (state),
    .nxt        (state_next),
    .res        (res_next)
  );

  // title state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (s2_take) begin
        state <= state_next;
      end
      if (s2_take) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (s2_take) begin
      res <= res_next;
    end
  end

  assign out_byte      = res.out_byte;
  assign byte_valid    = res.byte_valid;
  assign title_done    = res.title_done;
  assign discard_title = res.discard_title;
  assign char_count    = res.char_count;

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    s2_take && s1_final |=> state == '0)
    else $error("title state not cleared after last word");

  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && byte_valid |-> out_byte != '0)
    else $error("emitted byte is zero");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> out_byte == '0)
    else $error("byte set without byte_valid");

  a_discard_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && discard_title |-> title_done)
    else $error("discard flag outside last word");

  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    s2_take && state.stopped && !s1_final |=> state.stopped
      && $stable(state.emitted_count))
    else $error("stopped title changed");

endmodule

// File: bench/utf16_title_to_ascii_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_title_to_ascii_test
// Self-checking bench for the UTF-16 title converter. Titles are built as
// queues of words: a short directed set of titles, then random titles with
// short, wide-heavy, over-long and surrogate-at-the-limit shapes. A clocked
// driver and monitor apply random gaps on both channels, with one long
// receiver hold-off. A local title model predicts every result in order.
// ----------------------------------------------------------------------------
module utf16_title_to_ascii_test;
  import u16t_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int TargetWords   = 870;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;
  localparam int HoldAfter     = 200;

  typedef struct packed {
    logic [UnitW-1:0] code;
    logic             fin;
  } title_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             unit_valid = 1'b0;
  logic             unit_ready;
  logic [UnitW-1:0] code_unit = '0;
  logic             final_unit = 1'b0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             byte_valid;
  logic             title_done;
  logic             discard_title;
  logic [CharW-1:0] char_count;

  utf16_title_to_ascii dut (
    .clk          (clk),
    .rst          (rst),
    .unit_valid   (unit_valid),
    .unit_ready   (unit_ready),
    .code_unit    (code_unit),
    .final_unit   (final_unit),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .title_done   (title_done),
    .discard_title(discard_title),
    .char_count   (char_count)
  );

  // title state of the local model
  logic [CharW-1:0] m_emitted = '0;
  logic [6:0]       m_wide = '0;
  logic [15:0]      m_units = '0;
  logic             m_space = 1'b0;
  logic             m_high = 1'b0;
  logic             m_stopped = 1'b0;

  title_word_t   word_queue[$];
  title_result_t expected_results[$];
  title_word_t   next_word;

  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int words_in = 0;
  int results_out = 0;
  int titles_done = 0;
  int titles_discarded = 0;
  int bytes_out = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  logic [UnitW-1:0] accented[8] = '{16'h00E4, 16'h00F6, 16'h00FC, 16'h00C4,
                                    16'h00D6, 16'h00DC, 16'h00DF, 16'h00E9};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_wide_point();
    if (m_wide < 7'd127) m_wide++;
  endfunction

  function automatic title_result_t convert_word(logic [UnitW-1:0] cu, logic fin);
    title_result_t    r;
    logic             go;
    logic             emit;
    logic [ByteW-1:0] ch;
    r = '0;
    go = !m_stopped;
    emit = 1'b0;
    ch = '0;
    if (go && m_high) begin
      m_high = 1'b0;
      note_wide_point();
      if (cu >= LowFirst && cu <= LowLast) begin
        if (m_units < 16'hFFFF) m_units++;
        go = 1'b0;
      end
    end
    if (go) begin
      if (m_units >= TitleUnits || m_emitted >= NameBuffer - 4) begin
        m_stopped = 1'b1;
      end else begin
        m_units++;
        if (cu == '0) begin
          m_stopped = 1'b1;
        end else if (cu == LineFeed || cu == CarRet) begin
          if (m_emitted > 0 && !m_space) begin
            ch = SpaceChar;
            emit = 1'b1;
          end
        end else if (cu >= HighFirst && cu <= HighLast) begin
          m_high = 1'b1;
        end else if (cu <= Latin1Top) begin
          emit = 1'b1;
          case (cu[7:0])
            8'hE4:   ch = "a";
            8'hF6:   ch = "o";
            8'hFC:   ch = "u";
            8'hC4:   ch = "A";
            8'hD6:   ch = "O";
            8'hDC:   ch = "U";
            8'hDF:   ch = "s";
            8'hE9:   ch = "e";
            default: ch = cu[7:0];
          endcase
        end else begin
          note_wide_point();
        end
      end
    end
    if (emit) begin
      m_emitted++;
      m_space = (ch == SpaceChar);
    end
    r.out_byte = ch;
    r.byte_valid = emit;
    r.title_done = fin;
    r.char_count = m_emitted;
    if (fin) begin
      if (m_high && !m_stopped) note_wide_point();
      r.discard_title = (m_emitted < 3) && (m_wide > 2);
      m_emitted = '0;
      m_wide = '0;
      m_units = '0;
      m_space = 1'b0;
      m_high = 1'b0;
      m_stopped = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [UnitW-1:0] printable();
    return UnitW'($urandom_range(16'h20, 16'h7E));
  endfunction

  task automatic queue_title(logic [UnitW-1:0] units[$]);
    foreach (units[i]) word_queue.push_back('{units[i], i == units.size() - 1});
  endtask

  // shape: 0 mixed, 1 mostly wide code points
  task automatic add_random_title(int len, int shape);
    logic [UnitW-1:0] units[$];
    int r;
    while (units.size() < len) begin
      r = $urandom_range(0, 99);
      if (shape == 1) begin
        if (r < 70) units.push_back(UnitW'($urandom_range(16'h0100, 16'hD7FF)));
        else if (r < 80) units.push_back(UnitW'($urandom_range(LowFirst, LowLast)));
        else units.push_back(printable());
      end else if (r < 35) begin
        units.push_back(printable());
      end else if (r < 43) begin
        units.push_back(r[0] ? LineFeed : CarRet);
      end else if (r < 51) begin
        units.push_back(accented[$urandom_range(0, 7)]);
      end else if (r < 58) begin
        units.push_back(UnitW'($urandom_range(16'h80, 16'hFF)));
      end else if (r < 68) begin
        units.push_back(UnitW'($urandom_range(16'h0100, 16'hFFFF)));
      end else if (r < 76) begin
        units.push_back(UnitW'($urandom_range(HighFirst, HighLast)));
        units.push_back(UnitW'($urandom_range(LowFirst, LowLast)));
      end else if (r < 80) begin
        units.push_back(UnitW'($urandom_range(HighFirst, HighLast)));
      end else if (r < 84) begin
        units.push_back(UnitW'($urandom_range(LowFirst, LowLast)));
      end else if (r < 87) begin
        units.push_back('0);
      end else begin
        units.push_back(UnitW'($urandom()));
      end
    end
    queue_title(units);
  endtask

  // pair placed around the unit limit, then more units that must be ignored
  task automatic add_limit_title();
    logic [UnitW-1:0] units[$];
    int lead;
    lead = $urandom_range(TitleUnits - 2, TitleUnits);
    repeat (lead) units.push_back(printable());
    units.push_back(UnitW'($urandom_range(HighFirst, HighLast)));
    units.push_back(UnitW'($urandom_range(LowFirst, LowLast)));
    repeat ($urandom_range(1, 4)) units.push_back(printable());
    queue_title(units);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else begin
      if (unit_valid && unit_ready) begin
        expected_results.push_back(convert_word(code_unit, final_unit));
        words_in++;
        send_gap = (words_in % 160 < 40) ? 0 : pick_gap();
      end
      if (!unit_valid || unit_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          unit_valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          next_word = word_queue.pop_front();
          unit_valid <= 1'b1;
          code_unit <= next_word.code;
          final_unit <= next_word.fin;
        end else begin
          unit_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    title_result_t got;
    title_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got = '{out_byte, byte_valid, title_done, discard_title, char_count};
        results_out++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result byte=%h valid=%b done=%b discard=%b count=%0d",
                   $time, got.out_byte, got.byte_valid, got.title_done,
                   got.discard_title, got.char_count);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch expected byte=%h valid=%b done=%b discard=%b count=%0d",
                     $time, want.out_byte, want.byte_valid, want.title_done,
                     want.discard_title, want.char_count);
            $display("%0t:          actual   byte=%h valid=%b done=%b discard=%b count=%0d",
                     $time, got.out_byte, got.byte_valid, got.title_done,
                     got.discard_title, got.char_count);
          end
          if (want.title_done) titles_done++;
          if (want.discard_title) titles_discarded++;
          if (want.byte_valid) bytes_out++;
        end
      end
      if (!hold_done && results_out >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (results_out % 150 >= 40 && $urandom_range(0, 99) < 20) recv_stall = pick_gap();
      end
    end
  end

  // watchdog on cycles without any accepted word or result
  always @(posedge clk) begin
    if (rst || (unit_valid && unit_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("utf16_title_to_ascii_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    // ascii, folds, latin-1, wide, pairs, lone surrogates, stop on zero
    queue_title('{16'h0041, 16'h007F, LineFeed, CarRet, 16'h0080, 16'h00FF,
                  16'h00E4, 16'h00F6, 16'h00FC, 16'h00C4, 16'h00D6, 16'h00DC,
                  16'h00DF, 16'h00E9, 16'h0100, 16'hFFFF, HighFirst, LowFirst,
                  HighLast, LowLast, HighLast, 16'h0041, LowFirst, HighFirst,
                  16'h0000, 16'h0041, 16'h0042});
    // newline at title start, high surrogate pending at the last word
    queue_title('{CarRet, HighFirst});
    // few chars, many wide points
    queue_title('{16'h0100, 16'h4E00, 16'hFFFE});
    while (word_queue.size() < TargetWords) begin
      r = $urandom_range(0, 99);
      if (r < 70) add_random_title($urandom_range(1, 24), 0);
      else if (r < 82) add_random_title($urandom_range(3, 8), 1);
      else if (r < 92) add_random_title($urandom_range(60, 80), 0);
      else add_limit_title();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (word_queue.size() != 0 || unit_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d words in %0d titles, %0d bytes emitted, %0d titles discarded",
             words_in, titles_done, bytes_out, titles_discarded);
    $display("including unit-limit, surrogate and stop cases, with a %0d-cycle output hold",
             HoldCycles);
    if (mismatches == 0) begin
      $display("utf16_title_to_ascii_test passed");
    end else begin
      $display("utf16_title_to_ascii_test failed");
    end
    $finish;
  end

endmodule
